// ----- hdl/ntw_pkg.sv -----
// Package: shared types and constants for the number-to-word tokenizer.
package ntw_pkg;

    localparam int ValueW = 63;
    localparam int TokenW = 60;
    // BCD digits held for a 63-bit value (max 9.22e18 -> 19 digits), padded to 21
    localparam int Digits = 21;
    localparam int BcdW = Digits * 4;
    localparam int ShiftCntW = 6;
    // groups: 0 = 10^18 .. 6 = units
    localparam int Groups = 7;
    localparam int GroupW = 3;
    localparam int SlotW = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT,
        ST_HOLD
    } t_state;

    // slot within a group: hundreds digit, 100, tens, units, scale
    typedef enum logic [SlotW-1:0] {
        SL_HUND,
        SL_HUNDRED,
        SL_TENS,
        SL_UNITS,
        SL_SCALE
    } t_slot;

    typedef struct packed {
        logic load;
        logic shift;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic tok_valid;
        logic tok_last;
        logic walk_done;
    } t_stat;

    function automatic logic [TokenW-1:0] scale_token(input logic [GroupW-1:0] g);
        logic [TokenW-1:0] r;
        case (g)
            3'd0:    r = 60'd1000000000000000000;
            3'd1:    r = 60'd1000000000000000;
            3'd2:    r = 60'd1000000000000;
            3'd3:    r = 60'd1000000000;
            3'd4:    r = 60'd1000000;
            3'd5:    r = 60'd1000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/ntw_datapath.sv -----
// Datapath: shift-add-3 binary to BCD converter and a token walker.
module ntw_datapath (
    input  logic                        i_clk,
    input  logic [ntw_pkg::ValueW-1:0]  i_value,
    input  ntw_pkg::t_cmd               i_cmd,
    output ntw_pkg::t_stat              o_stat,
    output logic [ntw_pkg::TokenW-1:0]  o_token
);
    localparam int TokenW_LOC = ntw_pkg::TokenW;

    logic [ntw_pkg::ValueW-1:0]    r_bin, n_bin;
    logic [ntw_pkg::BcdW-1:0]      r_bcd, n_bcd;
    logic [ntw_pkg::ShiftCntW-1:0] r_cnt, n_cnt;
    logic [ntw_pkg::GroupW-1:0]    r_grp, n_grp;
    ntw_pkg::t_slot                r_slot, n_slot;
    logic [ntw_pkg::BcdW-1:0]      adj;

    // digits of the current group
    logic [3:0] d_h, d_t, d_u;
    logic [4:0] dig_base;
    logic       slot_ok;
    logic       grp_nz;
    logic [4:0] rem;
    logic [TokenW_LOC-1:0] tok;

    // search for next emitting position
    logic [ntw_pkg::GroupW-1:0] s_grp;
    ntw_pkg::t_slot             s_slot;
    logic                       s_found;

    // add-3 on each BCD digit
    always_comb begin
        for (int k = 0; k < ntw_pkg::Digits; k++) begin
            adj[k*4 +: 4] = (r_bcd[k*4 +: 4] >= 4'd5) ? r_bcd[k*4 +: 4] + 4'd3
                                                       : r_bcd[k*4 +: 4];
        end
    end

    // does (g, s) emit a token
    function automatic logic emits(input logic [ntw_pkg::BcdW-1:0] b,
                                   input logic [ntw_pkg::GroupW-1:0] g,
                                   input ntw_pkg::t_slot s);
        logic [4:0] base;
        logic [3:0] h, t, u;
        logic       e;
        base = 5'(6 - 32'(g)) * 5'd3;
        h = b[(32'(base) + 2) * 4 +: 4];
        t = b[(32'(base) + 1) * 4 +: 4];
        u = b[32'(base) * 4 +: 4];
        case (s)
            ntw_pkg::SL_HUND:    e = (h != 0);
            ntw_pkg::SL_HUNDRED: e = (h != 0);
            ntw_pkg::SL_TENS:    e = (t >= 4'd2);
            ntw_pkg::SL_UNITS:   e = (t == 4'd1) || (u != 0);
            ntw_pkg::SL_SCALE:   e = (g != 3'd6) && ((h | t | u) != 0);
            default:             e = 1'b0;
        endcase
        return e;
    endfunction

    // scan forward from current position (at most 35 positions, independent tests)
    always_comb begin
        logic [ntw_pkg::GroupW-1:0] g;
        ntw_pkg::t_slot s;
        s_found = 1'b0;
        s_grp = r_grp;
        s_slot = r_slot;
        for (int p = 34; p >= 0; p--) begin
            g = 3'(p / 5);
            s = ntw_pkg::t_slot'(3'(p % 5));
            if (({g, s} > {r_grp, r_slot}) && emits(r_bcd, g, s)) begin
                s_found = 1'b1;
                s_grp = g;
                s_slot = s;
            end
        end
    end

    assign dig_base = 5'(6 - 32'(r_grp)) * 5'd3;
    assign d_h = r_bcd[(32'(dig_base) + 2) * 4 +: 4];
    assign d_t = r_bcd[(32'(dig_base) + 1) * 4 +: 4];
    assign d_u = r_bcd[32'(dig_base) * 4 +: 4];
    assign slot_ok = emits(r_bcd, r_grp, r_slot);
    assign grp_nz = 1'b1;
    assign rem = (d_t == 4'd1) ? 5'd10 + 5'(d_u) : 5'(d_u);

    // token value of the current position
    always_comb begin
        case (r_slot)
            ntw_pkg::SL_HUND:    tok = TokenW_LOC'(d_h);
            ntw_pkg::SL_HUNDRED: tok = TokenW_LOC'(100);
            ntw_pkg::SL_TENS:    tok = TokenW_LOC'(7'(d_t) * 7'd10);
            ntw_pkg::SL_UNITS:   tok = TokenW_LOC'(rem);
            ntw_pkg::SL_SCALE:   tok = ntw_pkg::scale_token(r_grp);
            default:             tok = '0;
        endcase
    end

    // next-state of the datapath registers
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        n_grp = r_grp;
        n_slot = r_slot;
        if (i_cmd.load) begin
            n_bin = i_value;
            n_bcd = '0;
            n_cnt = '0;
            n_grp = '0;
            n_slot = ntw_pkg::SL_HUND;
        end else if (i_cmd.shift) begin
            n_bcd = {adj[ntw_pkg::BcdW-2:0], r_bin[ntw_pkg::ValueW-1]};
            n_bin = {r_bin[ntw_pkg::ValueW-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
        end else if (i_cmd.advance) begin
            if (s_found) begin
                n_grp = s_grp;
                n_slot = s_slot;
            end else begin
                n_grp = 3'd7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_grp <= n_grp;
        r_slot <= n_slot;
    end

    assign o_stat.conv_done = (r_cnt == ntw_pkg::ShiftCntW'(ntw_pkg::ValueW));
    assign o_stat.tok_valid = (r_grp != 3'd7) && slot_ok && grp_nz;
    assign o_stat.tok_last = !s_found;
    assign o_stat.walk_done = (r_grp == 3'd7);
    assign o_token = tok;
endmodule

// ----- hdl/ntw_ctrl.sv -----
// Controller: sequences conversion, token walk and output handoff.
module ntw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_out_stall,
    output logic           o_valid,
    input  ntw_pkg::t_stat i_stat,
    output ntw_pkg::t_cmd  o_cmd,
    output logic           o_capture
);
    ntw_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        o_capture = 1'b0;
        case (r_state)
            ntw_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ntw_pkg::ST_CONV;
                end
            end
            ntw_pkg::ST_CONV: begin
                if (i_stat.conv_done) begin
                    n_state = ntw_pkg::ST_EMIT;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            ntw_pkg::ST_EMIT: begin
                // skip non-emitting positions, present emitting ones
                if (i_stat.walk_done) begin
                    n_state = ntw_pkg::ST_IDLE;
                end else if (!i_stat.tok_valid) begin
                    o_cmd.advance = 1'b1;
                end else begin
                    o_capture = 1'b1;
                    o_cmd.advance = 1'b1;
                    n_state = ntw_pkg::ST_HOLD;
                end
            end
            ntw_pkg::ST_HOLD: begin
                o_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = ntw_pkg::ST_EMIT;
                end
            end
            default: n_state = ntw_pkg::ST_IDLE;
        endcase
    end
endmodule

// ----- hdl/number_to_word_tokens_core.sv -----
// Top level: number-to-English word token generator.
//   channel | direction | fields
//   input   | in        | i_value
//   output  | out       | o_token, o_last
// An item is accepted, converted by 63 shift-add-3 steps and a finishing step,
// then the walk leaves the always-empty top hundreds slot; each token (at most
// 31) takes a walk step and an output handoff, and a final step returns to
// idle. Output is registered; a stall holds the token. Reset is synchronous,
// active low, and returns the controller to idle.
module number_to_word_tokens_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [ntw_pkg::ValueW-1:0] i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [ntw_pkg::TokenW-1:0] o_token,
    output logic                       o_last
);
    ntw_pkg::t_cmd  cmd;
    ntw_pkg::t_stat stat;
    logic           capture;
    logic [ntw_pkg::TokenW-1:0] tok;
    logic [ntw_pkg::TokenW-1:0] r_token;
    logic           r_last;

    ntw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_out_stall (i_stall),
        .o_valid     (o_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_capture   (capture)
    );

    ntw_datapath u_dp (
        .i_clk   (i_clk),
        .i_value (i_value),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_token (tok)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_token <= tok;
            r_last <= stat.tok_last;
        end
    end

    assign o_token = r_token;
    assign o_last = r_last;

    // tokens are never zero
    a_tok_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_token != '0)) else $error("zero token");
    // commands are exclusive
    a_cmd_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd)) else $error("overlapping commands");
    // no input accepted while a token is pending
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken during output");
endmodule

// ----- sim/number_to_word_tokens_checker.sv -----
// Checker: predicts the word tokens for each accepted number and compares outputs.
module number_to_word_tokens_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_stall_in,
    input  logic [ntw_pkg::ValueW-1:0] i_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [ntw_pkg::TokenW-1:0] i_token,
    input  logic                       i_last,
    output int                         o_errors,
    output int                         o_pending
);
    typedef struct packed {
        logic [ntw_pkg::TokenW-1:0] token;
        logic                       last;
    } t_word;

    t_word word_queue[$];
    int    errors = 0;

    assign o_errors  = errors;
    assign o_pending = word_queue.size();

    // Spell one group below 1000 into the queue
    function automatic void spell_group(input logic [63:0] g, ref t_word words[$]);
        logic [63:0] h;
        logic [63:0] t;
        h = g / 100;
        if (h != 0) begin
            words.push_back('{token: h[ntw_pkg::TokenW-1:0], last: 1'b0});
            words.push_back('{token: 60'd100, last: 1'b0});
        end
        g = g % 100;
        if (g >= 20) begin
            t = (g / 10) * 10;
            words.push_back('{token: t[ntw_pkg::TokenW-1:0], last: 1'b0});
            g = g - t;
        end
        if (g != 0)
            words.push_back('{token: g[ntw_pkg::TokenW-1:0], last: 1'b0});
    endfunction

    // Expected tokens of one number, most significant first
    function automatic void predict_words(input logic [ntw_pkg::ValueW-1:0] value);
        logic [63:0] scales[6];
        logic [63:0] rest;
        logic [63:0] q;
        t_word       words[$];
        scales = '{64'd1000000000000000000, 64'd1000000000000000, 64'd1000000000000,
                   64'd1000000000, 64'd1000000, 64'd1000};
        rest = {1'b0, value};
        for (int i = 0; i < 6; i++) begin
            q = rest / scales[i];
            rest = rest % scales[i];
            if (q != 0) begin
                spell_group(q, words);
                words.push_back('{token: scales[i][ntw_pkg::TokenW-1:0], last: 1'b0});
            end
        end
        spell_group(rest, words);
        if (words.size() > 0)
            words[words.size()-1].last = 1'b1;
        foreach (words[k])
            word_queue.push_back(words[k]);
    endfunction

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (word_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected token %0d last %0b", i_token, i_last);
                end else begin
                    if (i_token !== word_queue[0].token || i_last !== word_queue[0].last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected token %0d last %0b, got %0d last %0b",
                                     word_queue[0].token, word_queue[0].last, i_token, i_last);
                    end
                    void'(word_queue.pop_front());
                end
            end
            if (i_valid && !i_stall_in)
                predict_words(i_value);
        end
    end
endmodule

// ----- sim/number_to_word_tokens_core_tb.sv -----
// Testbench top: drives numbers into the tokenizer and reports the verdict.
module number_to_word_tokens_core_tb;
    localparam int CycleLimit = 400000;
    localparam int RandomItems = 89;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [ntw_pkg::ValueW-1:0] i_value = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [ntw_pkg::TokenW-1:0] o_token;
    logic                       o_last;
    int                         errors;
    int                         pending;
    int                         cycles = 0;
    int                         stall_mode = 0;

    always #6 i_clk = ~i_clk;

    number_to_word_tokens_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_value(i_value), .o_valid(o_valid), .i_stall(i_stall),
        .o_token(o_token), .o_last(o_last)
    );

    number_to_word_tokens_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_value(i_value), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_token(o_token), .i_last(o_last), .o_errors(errors), .o_pending(pending)
    );

    // Timeout guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver stall pattern: phases of none, light, heavy
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Present one number and hold it until accepted
    task automatic send_number(input logic [ntw_pkg::ValueW-1:0] value);
        i_value <= value;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Random number with a random digit length so every group gets exercised
    function automatic logic [ntw_pkg::ValueW-1:0] random_number();
        logic [63:0] r;
        logic [63:0] lim;
        int          digits;
        r = {$urandom, $urandom};
        r[63] = 1'b0;
        digits = $urandom_range(1, 19);
        lim = 1;
        for (int i = 0; i < digits && i < 18; i++)
            lim = lim * 10;
        if (digits < 19)
            r = r % lim;
        if ($urandom_range(0, 5) == 0)
            r = r - (r % 1000000);
        return r[ntw_pkg::ValueW-1:0];
    endfunction

    initial begin
        logic [ntw_pkg::ValueW-1:0] directed[$];
        int burst;
        directed = '{63'd0, 63'd1, 63'd19, 63'd20, 63'd21, 63'd99, 63'd100, 63'd110,
                     63'd999, 63'd1000, 63'd1001, 63'd1000000, 63'd1000000000000000000,
                     63'd9000000000000000000, 63'd123456789012345678,
                     63'd9223372036854775807, 63'd1000000001000, 63'd515015,
                     63'h2AAAAAAAAAAAAAAA, 63'h5555555555555555, 63'd700000000000000017};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed numbers
        foreach (directed[k]) begin
            send_number(directed[k]);
            if ($urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 5));
        end
        i_valid <= 1'b0;

        // Hold off until the block has drained
        while (pending != 0)
            @(negedge i_clk);

        // Random bursts
        for (int n = 0; n < RandomItems; ) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && n < RandomItems; b++, n++)
                send_number(random_number());
            idle_gap($urandom_range(1, 120));
        end
        i_valid <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (120) @(negedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/ntw_pkg.sv
hdl/ntw_datapath.sv
hdl/ntw_ctrl.sv
hdl/number_to_word_tokens_core.sv
sim/number_to_word_tokens_checker.sv
sim/number_to_word_tokens_core_tb.sv
